>>> rtl/sdf_circle_pixel_blend_top_macros.svh
// assertion macros for the circle pixel blend block
// used by the port checker, no other dependencies
`ifndef SDF_CIRCLE_PIXEL_BLEND_TOP_MACROS_SVH
`define SDF_CIRCLE_PIXEL_BLEND_TOP_MACROS_SVH

// same-cycle implication, off during reset
`define SDFC_ASSERT_IMPL(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sdfc: property failed");

// next-cycle implication, off during reset
`define SDFC_ASSERT_NEXT(lbl, ck, rst_n, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sdfc: property failed");

// checked at every edge, reset included
`define SDFC_ASSERT_ALWAYS(lbl, ck, cond) \
	lbl: assert property (@(posedge ck) (cond)) \
		else $error("sdfc: property failed");

`endif

>>> rtl/sdfc_pkg.sv
// shared types and constants of the circle pixel blend block
// no dependencies
package sdfc_pkg;

	localparam int COORD_BITS_DEF = 10;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;

	localparam int RING_FALLOFF  = 4;
	localparam int SOLID_FALLOFF = 3;

	// blend quotient before the falloff divide, and divide by 3 as multiply
	localparam int Q_W        = 10;
	localparam int DIV3_MUL   = 683;
	localparam int DIV3_SHIFT = 11;
	localparam int DIV3_W     = 20;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X   = 3'd0,
		REG_CENTER_Y   = 3'd1,
		REG_RADIUS     = 3'd2,
		REG_FILL_COLOR = 3'd3,
		REG_SOLID_MODE = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} color_t;

	typedef struct packed {
		logic [23:0] fill_color;
		logic        solid_mode;
	} cfg_t;

	typedef struct packed {
		logic       write_pixel;
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
	} result_t;

endpackage

>>> rtl/sdfc_pixel_if.sv
// input channel: one pixel coordinate and its background color per word
// no dependencies
interface sdfc_pixel_if #(
	parameter int COORD_BITS = 10
);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] pixel_x;
	logic [COORD_BITS-1:0] pixel_y;
	logic [7:0]            bg_red;
	logic [7:0]            bg_green;
	logic [7:0]            bg_blue;

	modport source (output valid, pixel_x, pixel_y, bg_red, bg_green, bg_blue, input ready);
	modport sink (input valid, pixel_x, pixel_y, bg_red, bg_green, bg_blue, output ready);
endinterface

>>> rtl/sdfc_result_if.sv
// output channel: write flag and resulting color per word
// no dependencies
interface sdfc_result_if;
	logic       valid;
	logic       ready;
	logic       write_pixel;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;

	modport source (output valid, write_pixel, out_red, out_green, out_blue, input ready);
	modport sink (input valid, write_pixel, out_red, out_green, out_blue, output ready);
endinterface

>>> rtl/sdfc_dist_front.sv
// front stages: offsets from the center, squares, squared distance
// uses sdfc_pkg
module sdfc_dist_front #(
	parameter int COORD_BITS = sdfc_pkg::COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic [2:0]            en,
	input  logic [COORD_BITS-1:0] pixel_x,
	input  logic [COORD_BITS-1:0] pixel_y,
	input  sdfc_pkg::color_t      bg,
	input  logic [COORD_BITS-1:0] center_x,
	input  logic [COORD_BITS-1:0] center_y,
	output logic [2*COORD_BITS:0] sum_s3,
	output sdfc_pkg::color_t      bg_s3
);

	logic [COORD_BITS-1:0]   dx_s1, dy_s1;
	logic [2*COORD_BITS-1:0] sqx_s2, sqy_s2;
	sdfc_pkg::color_t        bg_s1, bg_s2;

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dx_s1 <= (pixel_x >= center_x) ? pixel_x - center_x : center_x - pixel_x;
			dy_s1 <= (pixel_y >= center_y) ? pixel_y - center_y : center_y - pixel_y;
			bg_s1 <= bg;
		end
		if (en[1]) begin
			sqx_s2 <= (2*COORD_BITS)'(dx_s1) * (2*COORD_BITS)'(dx_s1);
			sqy_s2 <= (2*COORD_BITS)'(dy_s1) * (2*COORD_BITS)'(dy_s1);
			bg_s2  <= bg_s1;
		end
		if (en[2]) begin
			sum_s3 <= {1'b0, sqx_s2} + {1'b0, sqy_s2};
			bg_s3  <= bg_s2;
		end
	end

endmodule

>>> rtl/sdfc_root_stage.sv
// one digit of the restoring square root, one register stage
// uses sdfc_pkg
module sdfc_root_stage #(
	parameter int COORD_BITS = sdfc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = sdfc_pkg::FRAC_BITS_DEF,
	parameter int STEP       = 0
) (
	input  logic                            clk,
	input  logic                            en,
	input  logic [2*COORD_BITS+1:0]         sum_in,
	input  logic [COORD_BITS+FRAC_BITS+3:0] rem_in,
	input  logic [COORD_BITS+FRAC_BITS:0]   root_in,
	input  sdfc_pkg::color_t                bg_in,
	output logic [2*COORD_BITS+1:0]         sum_out,
	output logic [COORD_BITS+FRAC_BITS+3:0] rem_out,
	output logic [COORD_BITS+FRAC_BITS:0]   root_out,
	output sdfc_pkg::color_t                bg_out
);

	localparam int RW       = COORD_BITS + FRAC_BITS + 4;
	localparam int RTW      = COORD_BITS + FRAC_BITS + 1;
	localparam int BIT_POS  = 2*(COORD_BITS + FRAC_BITS) - 2*STEP;
	localparam bit HAS_PAIR = (BIT_POS >= 2*FRAC_BITS);
	localparam int PAIR_LSB = HAS_PAIR ? BIT_POS - 2*FRAC_BITS : 0;

	logic [1:0]    pair;
	logic [RW-1:0] rem_sh;
	logic [RW-1:0] trial;
	logic          take;

	// fraction digits bring in zero pairs
	assign pair   = HAS_PAIR ? sum_in[PAIR_LSB +: 2] : 2'b00;
	assign rem_sh = {rem_in[RW-3:0], pair};
	assign trial  = {1'b0, root_in, 2'b01};
	assign take   = (rem_sh >= trial);

	always_ff @(posedge clk) begin
		if (en) begin
			sum_out  <= sum_in;
			rem_out  <= take ? rem_sh - trial : rem_sh;
			root_out <= {root_in[RTW-2:0], take};
			bg_out   <= bg_in;
		end
	end

endmodule

>>> rtl/sdfc_blend.sv
// back stages: distance to the rim, write decision, per-channel blend
// uses sdfc_pkg
module sdfc_blend #(
	parameter int COORD_BITS = sdfc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = sdfc_pkg::FRAC_BITS_DEF
) (
	input  logic                          clk,
	input  logic [3:0]                    en,
	input  logic [COORD_BITS+FRAC_BITS:0] root,
	input  sdfc_pkg::color_t              bg,
	input  logic [COORD_BITS-1:0]         radius,
	input  sdfc_pkg::cfg_t                cfg,
	output sdfc_pkg::result_t             res_s4
);

	localparam int RTW = COORD_BITS + FRAC_BITS + 1;
	localparam int KW  = FRAC_BITS + 3;
	localparam int PW  = 8 + KW;
	localparam int NW  = PW + 1;
	localparam int QW  = sdfc_pkg::Q_W;
	localparam int DW  = sdfc_pkg::DIV3_W;

	localparam logic [KW-1:0] K_RING  = KW'(sdfc_pkg::RING_FALLOFF << FRAC_BITS);
	localparam logic [KW-1:0] K_SOLID = KW'(sdfc_pkg::SOLID_FALLOFF << FRAC_BITS);

	logic [RTW-1:0] rad;
	logic           in_disc, in_band;
	logic [RTW-1:0] ad;
	logic [KW-1:0]  kval;
	logic [7:0]     fg [3];

	logic           write_s1, fill_s1, solid_s1;
	logic [KW-1:0]  adc_s1, k_s1;
	sdfc_pkg::color_t bg_s1;

	logic [KW-1:0]  kmad;
	logic [7:0]     bgc [3];
	logic           write_s2, fill_s2, solid_s2;
	logic [PW-1:0]  pbg_s2 [3];
	logic [PW-1:0]  pfg_s2 [3];
	sdfc_pkg::color_t bg_s2;

	logic [NW-1:0]  num [3];
	logic           write_s3, fill_s3, solid_s3;
	logic [QW-1:0]  q_s3 [3];
	sdfc_pkg::color_t bg_s3;

	logic [DW-1:0]  d3 [3];
	logic [7:0]     mix [3];

	assign fg[0] = cfg.fill_color[7:0];
	assign fg[1] = cfg.fill_color[15:8];
	assign fg[2] = cfg.fill_color[23:16];

	// stage 1: signed distance magnitude and the write decision
	always_comb begin
		rad     = {1'b0, radius, {FRAC_BITS{1'b0}}};
		in_disc = (root < rad);
		ad      = in_disc ? rad - root : root - rad;
		kval    = cfg.solid_mode ? K_SOLID : K_RING;
		in_band = (ad <= {{(RTW-KW){1'b0}}, kval});
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			write_s1 <= cfg.solid_mode ? (in_disc || in_band) : in_band;
			fill_s1  <= cfg.solid_mode && in_disc;
			solid_s1 <= cfg.solid_mode;
			// clipped so the blend math stays in range outside the falloff band
			adc_s1   <= in_band ? ad[KW-1:0] : kval;
			k_s1     <= kval;
			bg_s1    <= bg;
		end
	end

	// stage 2: weighted products
	assign kmad   = k_s1 - adc_s1;
	assign bgc[0] = bg_s1.red;
	assign bgc[1] = bg_s1.green;
	assign bgc[2] = bg_s1.blue;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int c = 0; c < 3; c++) begin
				pbg_s2[c] <= PW'(bgc[c]) * PW'(adc_s1);
				pfg_s2[c] <= PW'(fg[c]) * PW'(kmad);
			end
			write_s2 <= write_s1;
			fill_s2  <= fill_s1;
			solid_s2 <= solid_s1;
			bg_s2    <= bg_s1;
		end
	end

	// stage 3: sum and drop the fraction bits
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			num[c] = {1'b0, pbg_s2[c]} + {1'b0, pfg_s2[c]};
		end
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int c = 0; c < 3; c++) begin
				q_s3[c] <= num[c][FRAC_BITS +: QW];
			end
			write_s3 <= write_s2;
			fill_s3  <= fill_s2;
			solid_s3 <= solid_s2;
			bg_s3    <= bg_s2;
		end
	end

	// stage 4: divide by the falloff and pick the color
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			d3[c]  = DW'(q_s3[c]) * DW'(sdfc_pkg::DIV3_MUL);
			mix[c] = solid_s3 ? d3[c][sdfc_pkg::DIV3_SHIFT +: 8] : q_s3[c][QW-1:2];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			res_s4.write_pixel <= write_s3;
			if (!write_s3) begin
				res_s4.out_red   <= bg_s3.red;
				res_s4.out_green <= bg_s3.green;
				res_s4.out_blue  <= bg_s3.blue;
			end else if (fill_s3) begin
				res_s4.out_red   <= fg[0];
				res_s4.out_green <= fg[1];
				res_s4.out_blue  <= fg[2];
			end else begin
				res_s4.out_red   <= mix[0];
				res_s4.out_green <= mix[1];
				res_s4.out_blue  <= mix[2];
			end
		end
	end

endmodule

>>> rtl/sdf_circle_pixel_blend_top.sv
// pipeline from accept to result: distance front stages, square-root digit stages, blend stages
// throughput: one pixel per cycle while the output is not stalled; the square root takes one digit per pipeline stage
// a stalled output holds its word and upstream stages keep filling any bubbles
// reset clears all stage valid bits and the configuration registers to zero
// uses sdfc_pkg, sdfc_pixel_if, sdfc_result_if, sdfc_dist_front, sdfc_root_stage, sdfc_blend
module sdf_circle_pixel_blend_top #(
	parameter int COORD_BITS = sdfc_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = sdfc_pkg::FRAC_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [sdfc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sdfc_pkg::CFG_W-1:0]     cfg_data,
	sdfc_pixel_if.sink                     pix,
	sdfc_result_if.source                  res
);

	localparam int N   = COORD_BITS + FRAC_BITS + 1;
	localparam int D   = N + 7;
	localparam int SW  = 2*COORD_BITS + 2;
	localparam int RW  = COORD_BITS + FRAC_BITS + 4;
	localparam int RTW = COORD_BITS + FRAC_BITS + 1;

	logic [COORD_BITS-1:0] center_x_q, center_y_q, radius_q;
	sdfc_pkg::cfg_t        cfg_q;

	logic [D-1:0] stage_valid_q;
	logic [D-1:0] en;

	sdfc_pkg::color_t      bg_in;
	logic [2*COORD_BITS:0] sum_front;

	logic [SW-1:0]    sum_w  [N+1];
	logic [RW-1:0]    rem_w  [N+1];
	logic [RTW-1:0]   root_w [N+1];
	sdfc_pkg::color_t bg_w   [N+1];

	sdfc_pkg::result_t res_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= '0;
			cfg_q      <= '0;
		end else if (cfg_we) begin
			case (sdfc_pkg::cfg_reg_t'(cfg_index))
				sdfc_pkg::REG_CENTER_X:   center_x_q       <= cfg_data[COORD_BITS-1:0];
				sdfc_pkg::REG_CENTER_Y:   center_y_q       <= cfg_data[COORD_BITS-1:0];
				sdfc_pkg::REG_RADIUS:     radius_q         <= cfg_data[COORD_BITS-1:0];
				sdfc_pkg::REG_FILL_COLOR: cfg_q.fill_color <= cfg_data[23:0];
				sdfc_pkg::REG_SOLID_MODE: cfg_q.solid_mode <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// a stage moves when empty or when the one after it moves
	always_comb begin
		en[D-1] = !stage_valid_q[D-1] || res.ready;
		for (int k = D-2; k >= 0; k--) begin
			en[k] = !stage_valid_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (en[0]) stage_valid_q[0] <= pix.valid;
			for (int k = 1; k < D; k++) begin
				if (en[k]) stage_valid_q[k] <= stage_valid_q[k-1];
			end
		end
	end

	assign pix.ready = en[0];
	assign bg_in     = '{blue: pix.bg_blue, green: pix.bg_green, red: pix.bg_red};

	sdfc_dist_front #(
		.COORD_BITS(COORD_BITS)
	) u_front (
		.clk      (clk),
		.en       (en[2:0]),
		.pixel_x  (pix.pixel_x),
		.pixel_y  (pix.pixel_y),
		.bg       (bg_in),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.sum_s3   (sum_front),
		.bg_s3    (bg_w[0])
	);

	assign sum_w[0]  = {1'b0, sum_front};
	assign rem_w[0]  = '0;
	assign root_w[0] = '0;

	for (genvar j = 0; j < N; j++) begin : g_root
		sdfc_root_stage #(
			.COORD_BITS (COORD_BITS),
			.FRAC_BITS  (FRAC_BITS),
			.STEP       (j)
		) u_stage (
			.clk      (clk),
			.en       (en[3+j]),
			.sum_in   (sum_w[j]),
			.rem_in   (rem_w[j]),
			.root_in  (root_w[j]),
			.bg_in    (bg_w[j]),
			.sum_out  (sum_w[j+1]),
			.rem_out  (rem_w[j+1]),
			.root_out (root_w[j+1]),
			.bg_out   (bg_w[j+1])
		);
	end

	sdfc_blend #(
		.COORD_BITS (COORD_BITS),
		.FRAC_BITS  (FRAC_BITS)
	) u_blend (
		.clk    (clk),
		.en     (en[3+N +: 4]),
		.root   (root_w[N]),
		.bg     (bg_w[N]),
		.radius (radius_q),
		.cfg    (cfg_q),
		.res_s4 (res_word)
	);

	assign res.valid       = stage_valid_q[D-1];
	assign res.write_pixel = res_word.write_pixel;
	assign res.out_red     = res_word.out_red;
	assign res.out_green   = res_word.out_green;
	assign res.out_blue    = res_word.out_blue;

endmodule

>>> rtl/sdfc_checker.sv
// port-level checks of the circle pixel blend block, bound to the top level
// uses sdf_circle_pixel_blend_top_macros.svh
`include "sdf_circle_pixel_blend_top_macros.svh"

module sdfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       write_pixel,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue
);

	// a stalled result word stays put
	`SDFC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(write_pixel) && $stable(out_red) && $stable(out_green) && $stable(out_blue))

	// with the output free to move every stage moves, so input is open
	`SDFC_ASSERT_IMPL(a_in_open, clk, arst_n, !out_valid || out_ready, in_ready)

	// handshake lines are never unknown out of reset
	`SDFC_ASSERT_IMPL(a_known_hs, clk, arst_n, 1'b1, !$isunknown({in_valid, in_ready, out_valid, out_ready}))

	// no result word while reset is held
	`SDFC_ASSERT_ALWAYS(a_reset_empty, clk, arst_n || !out_valid)

endmodule

bind sdf_circle_pixel_blend_top sdfc_checker u_sdfc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (pix.valid),
	.in_ready    (pix.ready),
	.out_valid   (res.valid),
	.out_ready   (res.ready),
	.write_pixel (res.write_pixel),
	.out_red     (res.out_red),
	.out_green   (res.out_green),
	.out_blue    (res.out_blue)
);

>>> tb/tb_top.sv
// testbench for the circle pixel blend block: directed edge cases, then random pixels
// clustered on the circle boundary under several settings and idle patterns
// depends on sdfc_pkg, sdfc_pixel_if, sdfc_result_if and sdf_circle_pixel_blend_top
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD = sdfc_pkg::COORD_BITS_DEF;
	localparam int FRAC = sdfc_pkg::FRAC_BITS_DEF;
	localparam int IDX_W = sdfc_pkg::CFG_IDX_W;
	localparam int DATA_W = sdfc_pkg::CFG_W;
	localparam int COORD_MAX = (1 << COORD) - 1;
	localparam int PHASES = 8;
	localparam int PIXELS_PER_PHASE = 116;
	localparam int LATENCY = COORD + FRAC + 8;
	localparam logic [IDX_W-1:0] REG_SPARE_LO = IDX_W'(sdfc_pkg::REG_SOLID_MODE) + 1'b1;

	typedef struct packed {
		logic [COORD-1:0] x;
		logic [COORD-1:0] y;
		sdfc_pkg::color_t bg;
	} pixel_word_t;

	typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

	class circle_scoreboard;
		logic [COORD-1:0]  center_x;
		logic [COORD-1:0]  center_y;
		logic [COORD-1:0]  radius;
		sdfc_pkg::cfg_t    cfg;
		sdfc_pkg::result_t shaded_q[$];
		int                errors;

		function new();
			center_x = '0;
			center_y = '0;
			radius = '0;
			cfg = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
			case (idx)
				sdfc_pkg::REG_CENTER_X: center_x = data[COORD-1:0];
				sdfc_pkg::REG_CENTER_Y: center_y = data[COORD-1:0];
				sdfc_pkg::REG_RADIUS: radius = data[COORD-1:0];
				sdfc_pkg::REG_FILL_COLOR: cfg.fill_color = data;
				sdfc_pkg::REG_SOLID_MODE: cfg.solid_mode = data[0];
				default: ;
			endcase
		endfunction

		// largest r with r*r <= v, one bit at a time
		static function longint unsigned fixed_root(longint unsigned v);
			longint unsigned r;
			longint unsigned cand;
			r = 0;
			for (int b = COORD + FRAC; b >= 0; b--) begin
				cand = r | (64'd1 << b);
				if (cand * cand <= v)
					r = cand;
			end
			return r;
		endfunction

		static function logic [7:0] mix(logic [7:0] bg, logic [7:0] fg,
				longint unsigned ad, longint unsigned k);
			return 8'((64'(bg) * ad + 64'(fg) * (k - ad)) / k);
		endfunction

		function sdfc_pkg::result_t shade(pixel_word_t p);
			longint unsigned dx, dy, root, rad, ad, k;
			bit in_disc, solid_fill, write;
			sdfc_pkg::color_t fg;
			sdfc_pkg::result_t r;
			fg = sdfc_pkg::color_t'(cfg.fill_color);
			dx = (p.x >= center_x) ? 64'(p.x) - 64'(center_x) : 64'(center_x) - 64'(p.x);
			dy = (p.y >= center_y) ? 64'(p.y) - 64'(center_y) : 64'(center_y) - 64'(p.y);
			// scale before the root so the result carries the fraction bits
			root = fixed_root((dx * dx + dy * dy) << (2 * FRAC));
			rad = 64'(radius) << FRAC;
			in_disc = root < rad;
			ad = in_disc ? rad - root : root - rad;
			k = 64'(cfg.solid_mode ? sdfc_pkg::SOLID_FALLOFF : sdfc_pkg::RING_FALLOFF) << FRAC;
			solid_fill = cfg.solid_mode && in_disc;
			write = solid_fill || (ad <= k);
			r.write_pixel = write;
			if (!write) begin
				r.out_red = p.bg.red;
				r.out_green = p.bg.green;
				r.out_blue = p.bg.blue;
			end else if (solid_fill) begin
				r.out_red = fg.red;
				r.out_green = fg.green;
				r.out_blue = fg.blue;
			end else begin
				r.out_red = mix(p.bg.red, fg.red, ad, k);
				r.out_green = mix(p.bg.green, fg.green, ad, k);
				r.out_blue = mix(p.bg.blue, fg.blue, ad, k);
			end
			return r;
		endfunction

		function void note(pixel_word_t p);
			shaded_q.push_back(shade(p));
		endfunction

		function int pending();
			return shaded_q.size();
		endfunction

		function void compare(string field, logic [7:0] exp_v, logic [7:0] act_v);
			if (exp_v !== act_v) begin
				errors++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, exp_v,
					act_v);
			end
		endfunction

		function void check(sdfc_pkg::result_t act);
			sdfc_pkg::result_t exp_r;
			if (shaded_q.size() == 0) begin
				errors++;
				$display("%0t: result word with none pending, expected nothing, actual %h",
					$time, act);
				return;
			end
			exp_r = shaded_q.pop_front();
			compare("write_pixel", 8'(exp_r.write_pixel), 8'(act.write_pixel));
			compare("out_red", exp_r.out_red, act.out_red);
			compare("out_green", exp_r.out_green, act.out_green);
			compare("out_blue", exp_r.out_blue, act.out_blue);
		endfunction
	endclass

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [IDX_W-1:0]  cfg_index;
	logic [DATA_W-1:0] cfg_data;
	idle_mode_t        mode = IDLE_NONE;
	circle_scoreboard  sb = new();

	sdfc_pixel_if #(.COORD_BITS(COORD)) pix_ch();
	sdfc_result_if res_ch();

	sdf_circle_pixel_blend_top #(
		.COORD_BITS(COORD),
		.FRAC_BITS (FRAC)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.pix      (pix_ch),
		.res      (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#(2_000_000);
		$display("DONE: errors detected");
		$finish;
	end

	function automatic bit idle_now(bit sender_side);
		int pct;
		case (mode)
			IDLE_NONE: pct = 0;
			IDLE_SENDER: pct = sender_side ? 87 : 0;
			IDLE_RECEIVER: pct = sender_side ? 0 : 87;
			default: pct = 9;
		endcase
		return $urandom_range(0, 99) < pct;
	endfunction

	initial begin
		res_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ch.ready = !idle_now(1'b0);
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_ch.valid && res_ch.ready)
			sb.check(sdfc_pkg::result_t'({res_ch.write_pixel, res_ch.out_red,
				res_ch.out_green, res_ch.out_blue}));
	end

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, data);
	endtask

	// upper bits of coordinate writes carry junk that must be dropped
	task automatic set_circle(int cx, int cy, int r, logic [23:0] fill, bit solid);
		write_reg(sdfc_pkg::REG_CENTER_X, {(DATA_W-COORD)'($urandom), COORD'(cx)});
		write_reg(sdfc_pkg::REG_CENTER_Y, {(DATA_W-COORD)'($urandom), COORD'(cy)});
		write_reg(sdfc_pkg::REG_RADIUS, {(DATA_W-COORD)'($urandom), COORD'(r)});
		write_reg(sdfc_pkg::REG_FILL_COLOR, fill);
		write_reg(sdfc_pkg::REG_SOLID_MODE, {(DATA_W-1)'($urandom), solid});
	endtask

	task automatic send_pixel(pixel_word_t p);
		@(negedge clk);
		while (idle_now(1'b1)) begin
			pix_ch.valid = 1'b0;
			@(negedge clk);
		end
		pix_ch.valid = 1'b1;
		pix_ch.pixel_x = p.x;
		pix_ch.pixel_y = p.y;
		pix_ch.bg_red = p.bg.red;
		pix_ch.bg_green = p.bg.green;
		pix_ch.bg_blue = p.bg.blue;
		do @(posedge clk); while (!pix_ch.ready);
		sb.note(p);
	endtask

	task automatic send_at(int x, int y, logic [23:0] bg);
		pixel_word_t p;
		p.x = COORD'(x);
		p.y = COORD'(y);
		p.bg = sdfc_pkg::color_t'(bg);
		send_pixel(p);
	endtask

	task automatic drain();
		@(negedge clk);
		pix_ch.valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// mostly points within a few pixels of the circle, the rest anywhere
	function automatic pixel_word_t next_pixel();
		int t, dx, dy, tmp;
		pixel_word_t p;
		p.bg = sdfc_pkg::color_t'(24'($urandom));
		if ($urandom_range(0, 9) < 3) begin
			p.x = COORD'($urandom);
			p.y = COORD'($urandom);
			return p;
		end
		t = int'(sb.radius) + int'($urandom_range(0, 12)) - 6;
		if (t < 0)
			t = 0;
		dx = int'($urandom_range(0, t));
		dy = int'($floor($sqrt(real'(t * t - dx * dx)))) + int'($urandom_range(0, 2)) - 1;
		if (dy < 0)
			dy = 0;
		if ($urandom_range(0, 1)) begin
			tmp = dx;
			dx = dy;
			dy = tmp;
		end
		p.x = (int'(sb.center_x) + dx <= COORD_MAX) ? COORD'(int'(sb.center_x) + dx)
			: COORD'(int'(sb.center_x) - dx);
		p.y = (int'(sb.center_y) + dy <= COORD_MAX) ? COORD'(int'(sb.center_y) + dy)
			: COORD'(int'(sb.center_y) - dy);
		return p;
	endfunction

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = sdfc_pkg::REG_CENTER_X;
		cfg_data = '0;
		pix_ch.valid = 1'b0;
		pix_ch.pixel_x = '0;
		pix_ch.pixel_y = '0;
		pix_ch.bg_red = '0;
		pix_ch.bg_green = '0;
		pix_ch.bg_blue = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ring: on the line, band limits on both sides, center, diagonal, far corners
		set_circle(512, 512, 100, 24'h3C5AF0, 1'b0);
		send_at(612, 512, 24'h000000);
		send_at(616, 512, 24'hFFFFFF);
		send_at(617, 512, 24'h808080);
		send_at(608, 512, 24'h0000FF);
		send_at(607, 512, 24'hFF0000);
		send_at(512, 512, 24'h00FF00);
		send_at(583, 583, 24'hFFFFFF);
		send_at(0, 0, 24'h000000);
		send_at(COORD_MAX, COORD_MAX, 24'hFFFFFF);
		drain();

		// disc: deep inside, on the line, just inside, band limit, just past it
		set_circle(512, 512, 100, 24'hFFFFFF, 1'b1);
		send_at(512, 512, 24'h000000);
		send_at(612, 512, 24'h000000);
		send_at(611, 512, 24'h55AA55);
		send_at(615, 512, 24'h000000);
		send_at(616, 512, 24'h000000);
		send_at(583, 583, 24'h123456);
		drain();

		// zero radius at the origin
		set_circle(0, 0, 0, 24'h000000, 1'b0);
		send_at(0, 0, 24'hFFFFFF);
		send_at(3, 0, 24'hFFFFFF);
		send_at(COORD_MAX, COORD_MAX, 24'hFFFFFF);
		drain();

		// largest radius from the far corner
		set_circle(COORD_MAX, COORD_MAX, COORD_MAX, 24'hA5A5A5, 1'b1);
		send_at(0, COORD_MAX, 24'h5A5A5A);
		send_at(0, 0, 24'h5A5A5A);
		send_at(COORD_MAX, COORD_MAX, 24'h000000);
		drain();

		// unused register indexes have no effect
		for (int i = REG_SPARE_LO; i < (1 << IDX_W); i++)
			write_reg(IDX_W'(i), DATA_W'($urandom));

		for (int p = 0; p < PHASES; p++) begin
			mode = idle_mode_t'(p % 4);
			set_circle(p == 2 ? 0 : (p == 5 ? COORD_MAX : int'($urandom_range(0, COORD_MAX))),
				p == 2 ? 0 : (p == 5 ? COORD_MAX : int'($urandom_range(0, COORD_MAX))),
				p == 1 ? 0 : ((p == 2 || p == 5) ? COORD_MAX : int'($urandom_range(0, 600))),
				p == 3 ? 24'h000000 : (p == 4 ? 24'hFFFFFF : 24'($urandom)),
				p[0]);
			repeat (PIXELS_PER_PHASE)
				send_pixel(next_pixel());
			drain();
		end

		repeat (2 * LATENCY) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
